FILE: rtl/lir_pkg.sv
package lir_pkg;

	// field widths fixed by the stream format
	localparam int SAMPLE_W = 16;
	localparam int STEP_W = 21;
	localparam int CFG_INDEX_W = 8;

	// default fixed-point format of the phase
	localparam int FRAC_BITS_DEF = 16;

	// cap on outputs caused by one frame
	localparam int MAX_OUT = 64;
	localparam int CNT_W = $clog2(MAX_OUT);

	// register reset values
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
	localparam logic STEREO_RESET = 1'b1;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_STEREO_MODE = CFG_INDEX_W'(1);

	// input opcodes
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic flush;
		logic issue;
		logic skip;
	} lir_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic run_ok;
		logic pipe_ready;
		logic issue_last;
	} lir_status_t;

endpackage

FILE: rtl/lir_ctrl.sv
module lir_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_opcode,
	output logic                 s_tready,
	input  lir_pkg::lir_status_t status,
	output lir_pkg::lir_cmd_t    cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   take;

	assign s_tready = ready_q;
	assign take = s_tvalid && ready_q;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.load = take && (s_opcode == lir_pkg::OP_FRAME);
		cmd.flush = take && (s_opcode == lir_pkg::OP_FLUSH);
		if (state_q == ST_RUN) begin
			cmd.skip = !status.run_ok;
			cmd.issue = status.run_ok && status.pipe_ready;
		end
	end

	// state and ready register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
						ready_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (cmd.skip || (cmd.issue && status.issue_last)) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	// a run only ends from the run state
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue || cmd.skip) |-> (state_q == ST_RUN && !ready_q))
		else $error("run command outside run state");

	// no new word is taken while a frame is running
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !take)
		else $error("input word taken during run");

endmodule

FILE: rtl/lir_datapath.sv
module lir_datapath #(
	parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [lir_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [lir_pkg::STEP_W-1:0]          cfg_data,
	// input samples
	input  logic signed [lir_pkg::SAMPLE_W-1:0] sample_left,
	input  logic signed [lir_pkg::SAMPLE_W-1:0] sample_right,
	// control
	input  lir_pkg::lir_cmd_t                   cmd,
	output lir_pkg::lir_status_t                status,
	// result words
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic signed [lir_pkg::SAMPLE_W-1:0] out_left,
	output logic signed [lir_pkg::SAMPLE_W-1:0] out_right,
	output logic                                last_of_run
);

	localparam int SW = lir_pkg::SAMPLE_W;
	localparam int DW = SW + 1;
	localparam int PH_MAX_W = (FRAC_BITS + 1 > lir_pkg::STEP_W) ? FRAC_BITS + 1
		: lir_pkg::STEP_W;
	localparam int PW = PH_MAX_W + 1;
	localparam int MW = FRAC_BITS + 2;
	localparam int PRODW = DW + MW;
	localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;

	// configuration registers
	logic [lir_pkg::STEP_W-1:0] step_q;
	logic                       stereo_q;

	// history and phase
	logic signed [SW-1:0] prev_l_q, prev_r_q;
	logic signed [SW-1:0] cur_l_q, cur_r_q;
	logic [PW-1:0]        phase_q;
	logic [lir_pkg::CNT_W-1:0] cnt_q;

	// multiply stage
	logic                    valid_s1;
	logic signed [PRODW-1:0] prod_l_s1, prod_r_s1;
	logic signed [SW-1:0]    a_l_s1, a_r_s1;
	logic                    r_en_s1;
	logic                    last_s1;

	// output stage
	logic                 valid_s2;
	logic signed [SW-1:0] out_l_s2, out_r_s2;
	logic                 last_s2;

	logic [PW-1:0]           next_phase, commit_phase;
	logic                    commit;
	logic                    adv_s1;
	logic signed [DW-1:0]    diff_l, diff_r;
	logic signed [MW-1:0]    ph_s;
	logic signed [PRODW-1:0] prod_l, prod_r;
	logic signed [DW-1:0]    q_l, q_r, sum_l, sum_r;

	// configuration write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lir_pkg::STEP_RESET;
			stereo_q <= lir_pkg::STEREO_RESET;
		end else if (cfg_we) begin
			if (cfg_index == lir_pkg::REG_PHASE_STEP) begin
				step_q <= cfg_data;
			end else if (cfg_index == lir_pkg::REG_STEREO_MODE) begin
				stereo_q <= cfg_data[0];
			end
		end
	end

	// phase advance and end-of-run test
	assign next_phase = phase_q + PW'(step_q);
	assign commit = (cmd.issue && status.issue_last) || cmd.skip;
	assign commit_phase = cmd.issue ? next_phase : phase_q;
	assign adv_s1 = valid_s1 && (!valid_s2 || m_tready);

	always_comb begin
		status.run_ok = (phase_q <= ONE);
		status.pipe_ready = !valid_s1 || adv_s1;
		status.issue_last = (next_phase > ONE) ||
			(cnt_q == lir_pkg::CNT_W'(lir_pkg::MAX_OUT - 1));
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
			phase_q <= ONE;
			cnt_q <= '0;
		end else begin
			if (cmd.flush) begin
				prev_l_q <= '0;
				prev_r_q <= '0;
				phase_q <= ONE;
			end else if (commit) begin
				phase_q <= (commit_phase > ONE) ? commit_phase - ONE : '0;
				prev_l_q <= cur_l_q;
				if (stereo_q) begin
					prev_r_q <= cur_r_q;
				end
			end else if (cmd.issue) begin
				phase_q <= next_phase;
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.issue) begin
				cnt_q <= cnt_q + lir_pkg::CNT_W'(1);
			end
		end
	end

	// current frame latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_l_q <= sample_left;
			cur_r_q <= sample_right;
		end
	end

	// difference times phase, phase is at most one here
	assign diff_l = DW'(cur_l_q) - DW'(prev_l_q);
	assign diff_r = DW'(cur_r_q) - DW'(prev_r_q);
	assign ph_s = $signed({1'b0, phase_q[FRAC_BITS:0]});
	assign prod_l = diff_l * ph_s;
	assign prod_r = diff_r * ph_s;

	// multiply stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.issue) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			prod_l_s1 <= prod_l;
			prod_r_s1 <= prod_r;
			a_l_s1 <= prev_l_q;
			a_r_s1 <= prev_r_q;
			r_en_s1 <= stereo_q;
			last_s1 <= status.issue_last;
		end
	end

	// floor shift and add back the previous sample
	assign q_l = prod_l_s1[FRAC_BITS +: DW];
	assign q_r = prod_r_s1[FRAC_BITS +: DW];
	assign sum_l = DW'(a_l_s1) + q_l;
	assign sum_r = DW'(a_r_s1) + q_r;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_l_s2 <= sum_l[SW-1:0];
			out_r_s2 <= r_en_s1 ? sum_r[SW-1:0] : '0;
			last_s2 <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign out_left = out_l_s2;
	assign out_right = out_r_s2;
	assign last_of_run = last_s2;

	// an output is only started at a position inside the current interval
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (status.run_ok && status.pipe_ready))
		else $error("issue outside interval or into a full stage");

	// the stored phase after a run never exceeds its bound
	assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (phase_q <= ONE || phase_q < PW'(1) << lir_pkg::STEP_W))
		else $error("phase out of range after run");

	// the last output of a full-length run is marked
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && cnt_q == lir_pkg::CNT_W'(lir_pkg::MAX_OUT - 1))
		|=> (valid_s1 && last_s1))
		else $error("run cap reached without last mark");

endmodule

FILE: rtl/linear_interp_resampler_top.sv
// Linear interpolation sample rate converter for 16-bit PCM frames. Each frame word
// (left in tdata[15:0], right in tdata[31:16], tuser = 0) produces one output word for
// every output position between the previous and this frame, phase_step being the input
// over output rate with FRAC_BITS fractional bits; tlast marks the final word of a frame,
// and a frame may produce none or up to 64. A word with tuser = 1 flushes history and
// phase and produces nothing. A frame is accepted and then runs, issuing one output per
// cycle while downstream does not stall, or finding that it produces none; no new word
// is taken until the run ends. Outputs come from the single issue slot of the controller
// feeding one multiply stage. Each output is issued into the multiply stage register,
// then passes to the output register; downstream stalls hold the run. Configuration
// writes are always accepted and must only be made while the block is idle.
module linear_interp_resampler_top #(
	parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [31:0]                         s_tdata,  // sample_left, sample_right
	input  logic                                s_tuser,  // opcode
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [31:0]                         m_tdata,  // out_left, out_right
	output logic                                m_tlast,  // last_of_run
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lir_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [lir_pkg::STEP_W-1:0]          cfg_data
);

	localparam int SW = lir_pkg::SAMPLE_W;

	lir_pkg::lir_cmd_t    cmd;
	lir_pkg::lir_status_t status;
	logic signed [SW-1:0] out_left, out_right;

	assign cfg_ready = 1'b1;

	// sequencer
	lir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_opcode (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// interpolation datapath
	lir_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_left  (s_tdata[SW-1:0]),
		.sample_right (s_tdata[2*SW-1:SW]),
		.cmd          (cmd),
		.status       (status),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.out_left     (out_left),
		.out_right    (out_right),
		.last_of_run  (m_tlast)
	);

	// output word packing
	assign m_tdata = {out_right, out_left};

endmodule
